// ===== hw/rtl/hrlp_pkg.sv =====
// Shared types, codes and the method-name match for the request-line parser.
// No dependencies; every other file in this block imports it.
`default_nettype none

package hrlp_pkg;

   // Method codes reported on the summary item
   localparam logic [3:0] METHOD_UNSET   = 4'd0;
   localparam logic [3:0] METHOD_INVALID = 4'd1;
   localparam logic [3:0] METHOD_GET     = 4'd2;
   localparam logic [3:0] METHOD_PUT     = 4'd3;
   localparam logic [3:0] METHOD_HEAD    = 4'd4;
   localparam logic [3:0] METHOD_POST    = 4'd5;
   localparam logic [3:0] METHOD_TRACE   = 4'd6;
   localparam logic [3:0] METHOD_DELETE  = 4'd7;
   localparam logic [3:0] METHOD_CONNECT = 4'd8;
   localparam logic [3:0] METHOD_OPTIONS = 4'd9;

   // Result kinds
   localparam logic KIND_URI     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Default depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // Record handed from the front to the back through the queue
   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic       failed;
      logic       three_words;
      logic [3:0] method;
      logic [7:0] major;
      logic [3:0] minor;
   } rec_type;

   // Match the first len bytes of the line against the known method names
   function automatic logic [3:0] method_match(input logic [6:0][7:0] b,
                                               input logic [3:0]      len);
      logic [23:0] p3;
      logic [31:0] p4;
      logic [39:0] p5;
      logic [47:0] p6;
      logic [55:0] p7;
      logic [3:0]  code;
      p3   = {b[0], b[1], b[2]};
      p4   = {p3, b[3]};
      p5   = {p4, b[4]};
      p6   = {p5, b[5]};
      p7   = {p6, b[6]};
      code = METHOD_INVALID;
      if (len == 4'd3 && p3 == "GET") code = METHOD_GET;
      if (len == 4'd3 && p3 == "PUT") code = METHOD_PUT;
      if (len == 4'd4 && p4 == "HEAD") code = METHOD_HEAD;
      if (len == 4'd4 && p4 == "POST") code = METHOD_POST;
      if (len == 4'd5 && p5 == "TRACE") code = METHOD_TRACE;
      if (len == 4'd6 && p6 == "DELETE") code = METHOD_DELETE;
      if (len == 4'd7 && p7 == "CONNECT") code = METHOD_CONNECT;
      if (len == 4'd7 && p7 == "OPTIONS") code = METHOD_OPTIONS;
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hrlp_front.sv =====
// Front of the request-line parser: accepts bytes, walks the parse phases
// and pushes URI and summary records into the queue. Uses hrlp_pkg.
`default_nettype none

module hrlp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [7:0]          line_byte,
   input  wire logic                end_of_line,
   input  wire logic                take,
   output      logic                rec_valid,
   output      hrlp_pkg::rec_type   rec
);
   import hrlp_pkg::*;

   // Parse phases
   localparam logic [3:0] PH_START     = 4'd0;
   localparam logic [3:0] PH_METHOD    = 4'd1;
   localparam logic [3:0] PH_URI       = 4'd2;
   localparam logic [3:0] PH_PROTO     = 4'd3;
   localparam logic [3:0] PH_H         = 4'd4;
   localparam logic [3:0] PH_HT        = 4'd5;
   localparam logic [3:0] PH_HTT       = 4'd6;
   localparam logic [3:0] PH_HTTP      = 4'd7;
   localparam logic [3:0] PH_MAJ_FIRST = 4'd8;
   localparam logic [3:0] PH_MAJ       = 4'd9;
   localparam logic [3:0] PH_MIN_FIRST = 4'd10;
   localparam logic [3:0] PH_MIN       = 4'd11;
   localparam logic [3:0] PH_DONE      = 4'd12;

   logic [3:0]       phase_ff, phase_in;
   logic [6:0][7:0]  bytes_ff, bytes_in;
   logic [3:0]       pos_ff, pos_in;
   logic [2:0]       words_ff, words_in;
   logic             inword_ff, inword_in;
   logic [3:0]       method_ff, method_in;
   logic [7:0]       major_ff, major_in;
   logic [3:0]       minor_ff, minor_in;
   logic             failed_ff, failed_in;

   logic             is_ws, is_digit, is_crlf, forward;
   logic [3:0]       digit, matched;
   logic [11:0]      major_sum;

   // Classify the byte
   assign is_ws     = (line_byte == 8'd32) || (line_byte >= 8'd9 && line_byte <= 8'd13);
   assign is_digit  = (line_byte >= "0") && (line_byte <= "9");
   assign is_crlf   = (line_byte == 8'd10) || (line_byte == 8'd13);
   assign digit     = line_byte[3:0];
   assign matched   = (pos_ff >= 4'd3 && pos_ff <= 4'd7) ? method_match(bytes_ff, pos_ff)
                                                          : METHOD_INVALID;
   assign major_sum = ({4'd0, major_ff} * 12'd10) + {8'd0, digit};

   // Next state of the parser
   always_comb begin
      phase_in  = phase_ff;
      bytes_in  = bytes_ff;
      pos_in    = pos_ff;
      words_in  = words_ff;
      inword_in = inword_ff;
      method_in = method_ff;
      major_in  = major_ff;
      minor_in  = minor_ff;
      failed_in = failed_ff;
      forward   = 1'b0;

      // Capture the method bytes and advance the position
      if (pos_ff < 4'd7) begin
         bytes_in[pos_ff[2:0]] = line_byte;
      end
      if (pos_ff != 4'd15) begin
         pos_in = pos_ff + 4'd1;
      end

      // Count words
      if (is_ws) begin
         inword_in = 1'b0;
      end else if (!inword_ff) begin
         inword_in = 1'b1;
         if (words_ff != 3'd7) begin
            words_in = words_ff + 3'd1;
         end
      end

      unique case (phase_ff)
         PH_START: begin
            if (!is_crlf) begin
               if ((line_byte < "A" || line_byte > "Z") && line_byte != "_") begin
                  method_in = METHOD_INVALID;
                  failed_in = 1'b1;
                  phase_in  = PH_DONE;
               end else begin
                  phase_in = PH_METHOD;
               end
            end
         end
         PH_METHOD: begin
            if (line_byte == " ") begin
               if (matched == METHOD_INVALID) begin
                  method_in = METHOD_INVALID;
                  failed_in = 1'b1;
                  phase_in  = PH_DONE;
               end else begin
                  method_in = matched;
                  phase_in  = PH_URI;
               end
            end
         end
         PH_URI: begin
            if (line_byte == " ") begin
               phase_in = PH_PROTO;
            end else begin
               forward = 1'b1;
            end
         end
         PH_PROTO: begin
            priority if (line_byte == " ") begin
               phase_in = PH_PROTO;
            end else if (is_crlf) begin
               phase_in = PH_DONE;
            end else if (line_byte == "H") begin
               phase_in = PH_H;
            end else begin
               failed_in = 1'b1;
               phase_in  = PH_DONE;
            end
         end
         PH_H, PH_HT, PH_HTT, PH_HTTP: begin
            if ((phase_ff == PH_H    && line_byte == "T") ||
                (phase_ff == PH_HT   && line_byte == "T") ||
                (phase_ff == PH_HTT  && line_byte == "P") ||
                (phase_ff == PH_HTTP && line_byte == "/")) begin
               phase_in = phase_ff + 4'd1;
            end else begin
               method_in = METHOD_INVALID;
               failed_in = 1'b1;
               phase_in  = PH_DONE;
            end
         end
         PH_MAJ_FIRST: begin
            if (line_byte < "1" || line_byte > "9") begin
               method_in = METHOD_INVALID;
               failed_in = 1'b1;
               phase_in  = PH_DONE;
            end else begin
               major_in = {4'd0, digit};
               phase_in = PH_MAJ;
            end
         end
         PH_MAJ: begin
            priority if (line_byte == ".") begin
               phase_in = PH_MIN_FIRST;
            end else if (!is_digit) begin
               method_in = METHOD_INVALID;
               failed_in = 1'b1;
               phase_in  = PH_DONE;
            end else begin
               major_in = (major_sum > 12'd255) ? 8'd255 : major_sum[7:0];
            end
         end
         PH_MIN_FIRST: begin
            if (!is_digit) begin
               method_in = METHOD_INVALID;
               failed_in = 1'b1;
               phase_in  = PH_DONE;
            end else begin
               minor_in = digit;
               phase_in = PH_MIN;
            end
         end
         PH_MIN: begin
            if (is_crlf) begin
               phase_in = PH_DONE;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // Build the record for the queue
   always_comb begin
      rec.kind        = end_of_line ? KIND_SUMMARY : KIND_URI;
      rec.data        = line_byte;
      rec.failed      = failed_in;
      rec.three_words = (words_in == 3'd3);
      rec.method      = method_in;
      rec.major       = major_in;
      rec.minor       = minor_in;
   end
   assign rec_valid = take && (end_of_line || forward);

   // Hold the method bytes
   always_ff @(posedge clock) begin
      if (take) begin
         bytes_ff <= bytes_in;
      end
   end

   // Advance the parser; on the last byte drop all line state but the held method bytes
   always_ff @(posedge clock) begin
      if (reset || (take && end_of_line)) begin
         phase_ff  <= PH_START;
         pos_ff    <= 4'd0;
         words_ff  <= 3'd0;
         inword_ff <= 1'b0;
         method_ff <= METHOD_UNSET;
         major_ff  <= 8'd0;
         minor_ff  <= 4'd0;
         failed_ff <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         words_ff  <= words_in;
         inword_ff <= inword_in;
         method_ff <= method_in;
         major_ff  <= major_in;
         minor_ff  <= minor_in;
         failed_ff <= failed_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/hrlp_fifo.sv =====
// Short queue of result records between the parser front and the back.
// Uses hrlp_pkg for the record type.
`default_nettype none

module hrlp_fifo #(
   parameter int unsigned DEPTH = hrlp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr,
   input  wire hrlp_pkg::rec_type   wr_rec,
   input  wire logic                rd,
   output      hrlp_pkg::rec_type   rd_rec,
   output      logic                full,
   output      logic                nonempty
);
   import hrlp_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   rec_type          mem_ff [DEPTH];
   logic [PtrW-1:0]  wptr_ff, wptr_in;
   logic [PtrW-1:0]  rptr_ff, rptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign full     = (count_ff == FullCnt);
   assign nonempty = (count_ff != '0);
   assign rd_rec   = mem_ff[rptr_ff];

   // Advance pointers and the fill count
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (wr) begin
         wptr_in = (wptr_ff == LastPtr) ? '0 : wptr_ff + PtrW'(1);
      end
      if (rd) begin
         rptr_in = (rptr_ff == LastPtr) ? '0 : rptr_ff + PtrW'(1);
      end
      if (wr && !rd) begin
         count_in = count_ff + CntW'(1);
      end else if (rd && !wr) begin
         count_in = count_ff - CntW'(1);
      end
   end

   // Store the record
   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wptr_ff] <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr |-> (!full || rd))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd |-> nonempty)
      else $error("queue read while empty");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (wr && !rd) |=> (count_ff == $past(count_ff) + CntW'(1)))
      else $error("queue count did not advance on write");

endmodule

`default_nettype wire

// ===== hw/rtl/hrlp_back.sv =====
// Back of the request-line parser: takes records from the queue, formats
// URI or summary items and holds them in the output register. Uses hrlp_pkg.
`default_nettype none

module hrlp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_nonempty,
   input  wire hrlp_pkg::rec_type   q_rec,
   output      logic                q_rd,
   output      logic                out_empty,
   input  wire logic                out_pop,
   output      logic                kind,
   output      logic [7:0]          uri_byte,
   output      logic                status,
   output      logic [3:0]          method_code,
   output      logic [7:0]          ver_major,
   output      logic [3:0]          ver_minor
);
   import hrlp_pkg::*;

   logic        valid_ff;
   logic        kind_ff, kind_in;
   logic [7:0]  uri_ff, uri_in;
   logic        status_ff, status_in;
   logic [3:0]  method_ff, method_in;
   logic [7:0]  major_ff, major_in;
   logic [3:0]  minor_ff, minor_in;

   // Load a new item when the output register is free or being taken
   assign q_rd = q_nonempty && (!valid_ff || out_pop);

   // Format the item; a line without exactly three words is invalid
   always_comb begin
      kind_in   = q_rec.kind;
      uri_in    = 8'd0;
      status_in = 1'b0;
      method_in = METHOD_UNSET;
      major_in  = 8'd0;
      minor_in  = 4'd0;
      if (q_rec.kind == KIND_URI) begin
         uri_in = q_rec.data;
      end else if (q_rec.three_words) begin
         status_in = q_rec.failed;
         method_in = q_rec.method;
         major_in  = q_rec.major;
         minor_in  = q_rec.minor;
      end else begin
         status_in = 1'b1;
         method_in = METHOD_INVALID;
      end
   end

   always_ff @(posedge clock) begin
      if (q_rd) begin
         kind_ff   <= kind_in;
         uri_ff    <= uri_in;
         status_ff <= status_in;
         method_ff <= method_in;
         major_ff  <= major_in;
         minor_ff  <= minor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_rd) begin
         valid_ff <= 1'b1;
      end else if (out_pop) begin
         valid_ff <= 1'b0;
      end
   end

   assign out_empty   = !valid_ff;
   assign kind        = kind_ff;
   assign uri_byte    = uri_ff;
   assign status      = status_ff;
   assign method_code = method_ff;
   assign ver_major   = major_ff;
   assign ver_minor   = minor_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/http_request_line_parser_core.sv =====
// Top level of the HTTP request-line parser: front, record queue and back.
// Depends on hrlp_pkg, hrlp_front, hrlp_fifo and hrlp_back.
//
//   Channel   Ports                                      Handshake
//   request   req_line_byte, req_end_of_line             req_push / req_full
//   response  rsp_kind, rsp_uri_byte, rsp_status,        rsp_pop / rsp_empty
//             rsp_method_code, rsp_ver_major,
//             rsp_ver_minor
//
// One byte is taken every cycle while req_push is high and req_full is low;
// the front updates the parse state in the cycle the byte is taken and pushes
// any record for it on the same edge; records reach the result ports through
// the queue and the back's output register. req_full rises only when the
// queue (QUEUE_DEPTH entries) is full; the back reads it only while rsp_empty
// or rsp_pop is high. Synchronous reset returns the parser to the start of a
// line and empties both the queue and the output register.
`default_nettype none

module http_request_line_parser_core #(
   parameter int unsigned QUEUE_DEPTH = hrlp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output      logic        req_full,
   input  wire logic [7:0]  req_line_byte,
   input  wire logic        req_end_of_line,
   output      logic        rsp_empty,
   input  wire logic        rsp_pop,
   output      logic        rsp_kind,
   output      logic [7:0]  rsp_uri_byte,
   output      logic        rsp_status,
   output      logic [3:0]  rsp_method_code,
   output      logic [7:0]  rsp_ver_major,
   output      logic [3:0]  rsp_ver_minor
);
   import hrlp_pkg::*;

   logic     take;
   logic     rec_valid;
   rec_type  front_rec;
   rec_type  head_rec;
   logic     q_full, q_nonempty, q_rd;

   // Accept a byte whenever the queue has room
   assign req_full = q_full;
   assign take     = req_push && !q_full;

   hrlp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .line_byte   (req_line_byte),
      .end_of_line (req_end_of_line),
      .take        (take),
      .rec_valid   (rec_valid),
      .rec         (front_rec)
   );

   hrlp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr       (rec_valid),
      .wr_rec   (front_rec),
      .rd       (q_rd),
      .rd_rec   (head_rec),
      .full     (q_full),
      .nonempty (q_nonempty)
   );

   hrlp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_nonempty  (q_nonempty),
      .q_rec       (head_rec),
      .q_rd        (q_rd),
      .out_empty   (rsp_empty),
      .out_pop     (rsp_pop),
      .kind        (rsp_kind),
      .uri_byte    (rsp_uri_byte),
      .status      (rsp_status),
      .method_code (rsp_method_code),
      .ver_major   (rsp_ver_major),
      .ver_minor   (rsp_ver_minor)
   );

endmodule

`default_nettype wire
